/* hw/rtl/cdbr_pkg.sv */
package cdbr_pkg;

  localparam int BufferChars = 32;
  localparam int IdxW = (BufferChars > 1) ? $clog2(BufferChars) : 1;
  localparam int InitLen = 7;

  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] QuestChar = 8'h3F;
  localparam logic [7:0] ZeroChar = 8'h30;
  localparam logic [7:0] OneChar = 8'h31;
  localparam logic [7:0] NineChar = 8'h39;
  localparam logic [7:0] LowAChar = 8'h61;
  localparam logic [7:0] LowZChar = 8'h7A;
  localparam logic [7:0] EscChar = 8'h1B;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_CHAR  = 2'd1,
    FUNC_BUMP  = 2'd2,
    FUNC_VALUE = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_TICK_OUT,
    ST_BUMP_WRAP,
    ST_BUMP_WR,
    ST_VAL_DIV,
    ST_VAL_WR
  } state_e;

  // Display init sequence: ESC [ 0 h ESC [ j
  function automatic logic [7:0] init_byte(input logic [2:0] step);
    logic [7:0] b;
    b = EscChar;
    case (step)
      3'd0: b = EscChar;
      3'd1: b = 8'h5B;
      3'd2: b = 8'h30;
      3'd3: b = 8'h68;
      3'd4: b = EscChar;
      3'd5: b = 8'h5B;
      3'd6: b = 8'h6A;
      default: b = EscChar;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] bump_char(input logic [7:0] w);
    logic [7:0] r;
    if (w >= ZeroChar && w < NineChar) begin
      r = w + 8'd1;
    end else if (w == NineChar) begin
      r = LowAChar;
    end else if (w >= LowAChar && w < LowZChar) begin
      r = w + 8'd1;
    end else if (w == LowZChar) begin
      r = w;
    end else begin
      r = OneChar;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/cdbr_ram.sv */
module cdbr_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/cdbr_div10.sv */
module cdbr_div10 (
  input  logic [31:0] dividend_i,
  output logic [31:0] quotient_o
);

  logic [63:0] prod;

  // Multiply by the rounded-up reciprocal of ten; exact for all 32-bit inputs.
  assign prod = {32'd0, dividend_i} * 64'h0000_0000_CCCC_CCCD;
  assign quotient_o = {3'd0, prod[63:35]};

endmodule

/* hw/rtl/char_display_buffer_refresher_top.sv */
// Channel | Direction | Handshake                 | Payload
// input   | in        | in_valid_i / in_ready_o   | func_i pos_i ch_i value_i digit_count_i
// output  | out       | out_valid_o / out_ready_i | tx_byte_o
//
// Char write: RAM written when accepted. Tick: ST_TICK (init), or ST_TICK then
// ST_TICK_OUT (buffer RAM). Bump: ST_BUMP_WRAP subtracts BufferChars until pos
// fits, then ST_BUMP_WR. Value: per digit ST_VAL_DIV (reciprocal divide), then ST_VAL_WR (RAM write).
// Reset clears per-entry valid bits at once; an unwritten entry reads as space.
// A tick waits while the output register holds an untaken byte.
module char_display_buffer_refresher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  pos_i,
  input  logic [7:0]  ch_i,
  input  logic [31:0] value_i,
  input  logic [5:0]  digit_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o
);
  import cdbr_pkg::*;

  localparam logic [8:0] BufN9 = 9'(BufferChars);
  localparam logic [9:0] BufN10 = 10'(BufferChars);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BufferChars - 1);

  state_e state_q, state_d;
  logic [2:0] init_q, init_d;
  logic [IdxW-1:0] ref_q, ref_d;
  logic [BufferChars-1:0] vld_q, vld_d;
  logic ent_vld_q, ent_vld_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] tx_q, tx_d;
  logic [7:0] pos_q, pos_d;
  logic [31:0] val_q, val_d;
  logic [5:0] cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [7:0] wrap_q, wrap_d;

  logic we, re;
  logic [IdxW-1:0] waddr, raddr;
  logic [7:0] wdata, rdata, ent_data;
  logic [31:0] quotient, remainder;
  logic [9:0] dpos;
  logic slot_free, accept;

  cdbr_ram #(
    .Width(8),
    .Depth(BufferChars)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  cdbr_div10 u_div10 (
    .dividend_i(val_q),
    .quotient_o(quotient)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign ent_data = ent_vld_q ? rdata : SpaceChar;
  assign dpos = {2'd0, pos_q} + {4'd0, cnt_q} - 10'd1;
  assign remainder = val_q - {quo_q[28:0], 3'd0} - {quo_q[30:0], 1'b0};

  always_comb begin
    state_d = state_q;
    init_d = init_q;
    ref_d = ref_q;
    ent_vld_d = ent_vld_q;
    out_valid_d = out_valid_q && !out_ready_i;
    tx_d = tx_q;
    pos_d = pos_q;
    val_d = val_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    wrap_d = wrap_q;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    re = 1'b0;
    raddr = ref_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pos_d = pos_i;
          val_d = value_i;
          cnt_d = digit_count_i;
          wrap_d = pos_i;
          unique case (func_e'(func_i))
            FUNC_TICK: state_d = ST_TICK;
            FUNC_CHAR: begin
              if ({1'b0, pos_i} < BufN9) begin
                we = 1'b1;
                waddr = pos_i[IdxW-1:0];
                wdata = ch_i;
              end
            end
            FUNC_BUMP: state_d = ST_BUMP_WRAP;
            FUNC_VALUE: state_d = ST_VAL_DIV;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_TICK: begin
        if (init_q < 3'(InitLen)) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            tx_d = init_byte(init_q);
            init_d = init_q + 3'd1;
            state_d = ST_IDLE;
          end
        end else begin
          re = 1'b1;
          raddr = ref_q;
          ent_vld_d = vld_q[ref_q];
          state_d = ST_TICK_OUT;
        end
      end
      ST_TICK_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          tx_d = ent_data;
          ref_d = (ref_q == LastIdx) ? '0 : ref_q + IdxW'(1);
          state_d = ST_IDLE;
        end
      end
      ST_BUMP_WRAP: begin
        if ({1'b0, wrap_q} >= BufN9) begin
          wrap_d = wrap_q - BufN9[7:0];
        end else begin
          re = 1'b1;
          raddr = wrap_q[IdxW-1:0];
          ent_vld_d = vld_q[wrap_q[IdxW-1:0]];
          state_d = ST_BUMP_WR;
        end
      end
      ST_BUMP_WR: begin
        we = 1'b1;
        waddr = wrap_q[IdxW-1:0];
        wdata = bump_char(ent_data);
        state_d = ST_IDLE;
      end
      ST_VAL_DIV: begin
        if (cnt_q == 6'd0) begin
          // All digits taken: a leftover value marks the field as overflowed.
          if (val_q != 32'd0 && {1'b0, pos_q} < BufN9) begin
            we = 1'b1;
            waddr = pos_q[IdxW-1:0];
            wdata = QuestChar;
          end
          state_d = ST_IDLE;
        end else begin
          quo_d = quotient;
          state_d = ST_VAL_WR;
        end
      end
      ST_VAL_WR: begin
        if (dpos < BufN10) begin
          we = 1'b1;
          waddr = dpos[IdxW-1:0];
          wdata = ZeroChar + {4'd0, remainder[3:0]};
        end
        val_d = quo_q;
        cnt_d = cnt_q - 6'd1;
        state_d = ST_VAL_DIV;
      end
      default: state_d = ST_IDLE;
    endcase

    vld_d = vld_q;
    if (we) begin
      vld_d[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      init_q <= 3'd0;
      ref_q <= '0;
      vld_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q <= init_d;
      ref_q <= ref_d;
      vld_q <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_vld_q <= ent_vld_d;
    tx_q <= tx_d;
    pos_q <= pos_d;
    val_q <= val_d;
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    wrap_q <= wrap_d;
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o = tx_q;

endmodule

/* hw/rtl/cdbr_checker.sv */
module cdbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  func_i,
  input logic [7:0]  pos_i,
  input logic [7:0]  ch_i,
  input logic [31:0] value_i,
  input logic [5:0]  digit_count_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  tx_byte_o
);
  import cdbr_pkg::*;

  // A result stays offered, unchanged, until its transfer completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_byte_o))
    else $error("output dropped or changed while stalled");

  // A char write finishes in the cycle it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == FUNC_CHAR |=> in_ready_o)
    else $error("char write did not complete in one cycle");

  // Every other operation closes the input in the cycle after it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i != FUNC_CHAR |=> !in_ready_o)
    else $error("input reopened while an operation was in progress");

  // A new result only appears while a tick is being served.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result produced without a tick in progress");

endmodule

bind char_display_buffer_refresher_top cdbr_checker u_cdbr_checker (.*);

/* sim/tb_top.sv */
module tb_top;
  import cdbr_pkg::*;

  class display_scoreboard;
    logic [7:0]  shadow_text [BufferChars];
    logic [7:0]  init_bytes [InitLen];
    int unsigned refresh_idx;
    int unsigned init_sent;
    logic [7:0]  tx_bytes_due [$];
    int unsigned errors;

    function void reset_state();
      foreach (shadow_text[i]) shadow_text[i] = SpaceChar;
      // ESC [ 0 h ESC [ j
      init_bytes = '{EscChar, 8'h5B, 8'h30, 8'h68, EscChar, 8'h5B, 8'h6A};
      refresh_idx = 0;
      init_sent = 0;
      errors = 0;
      tx_bytes_due.delete();
    endfunction

    function logic [7:0] bumped_char(logic [7:0] w);
      logic [7:0] r;
      if (w >= ZeroChar && w < NineChar) begin
        r = w + 8'd1;
      end else if (w == NineChar) begin
        r = LowAChar;
      end else if (w >= LowAChar && w < LowZChar) begin
        r = w + 8'd1;
      end else if (w == LowZChar) begin
        r = w;
      end else begin
        r = OneChar;
      end
      return r;
    endfunction

    function void take_item(func_e f, logic [7:0] p, logic [7:0] c, logic [31:0] v,
                            logic [5:0] n);
      int unsigned slot;
      int unsigned k;
      logic [31:0] rest;
      case (f)
        FUNC_TICK: begin
          if (init_sent < InitLen) begin
            tx_bytes_due.push_back(init_bytes[init_sent]);
            init_sent++;
          end else begin
            tx_bytes_due.push_back(shadow_text[refresh_idx]);
            refresh_idx = (refresh_idx + 1) % BufferChars;
          end
        end
        FUNC_CHAR: begin
          if (p < BufferChars) shadow_text[p] = c;
        end
        FUNC_BUMP: begin
          slot = p % BufferChars;
          shadow_text[slot] = bumped_char(shadow_text[slot]);
        end
        default: begin
          // Digits are placed from the right; positions past the buffer are
          // dropped but the value is still divided down.
          rest = v;
          for (k = n; k > 0; k--) begin
            slot = p + k - 1;
            if (slot < BufferChars) shadow_text[slot] = 8'(rest % 10) + ZeroChar;
            rest = rest / 10;
          end
          if (rest != 0 && p < BufferChars) shadow_text[p] = QuestChar;
        end
      endcase
    endfunction

    function void check_tx_byte(logic [7:0] got);
      logic [7:0] want;
      if (tx_bytes_due.size() == 0) begin
        $display("%0t: tx_byte 0x%02h arrived with no transfer pending", $time, got);
        errors++;
      end else begin
        want = tx_bytes_due.pop_front();
        if (got !== want) begin
          $display("%0t: tx_byte mismatch: expected 0x%02h, actual 0x%02h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = FUNC_TICK;
  logic [7:0]  pos_i = '0;
  logic [7:0]  ch_i = '0;
  logic [31:0] value_i = '0;
  logic [5:0]  digit_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  tx_byte_o;

  display_scoreboard sb;
  logic        steady = 1'b0;
  int unsigned items_sent = 0;

  char_display_buffer_refresher_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .pos_i        (pos_i),
    .ch_i         (ch_i),
    .value_i      (value_i),
    .digit_count_i(digit_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tx_byte_o    (tx_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 12);
  end

  // Outputs are stable at the falling edge, so a transfer seen here completes
  // at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_tx_byte(tx_byte_o);
  end

  task automatic send_item(input func_e f, input logic [7:0] p, input logic [7:0] c,
                           input logic [31:0] v, input logic [5:0] n);
    if (!steady) begin
      while ($urandom_range(99) < 12) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    pos_i         <= p;
    ch_i          <= c;
    value_i       <= v;
    digit_count_i <= n;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    sb.take_item(f, p, c, v, n);
    items_sent++;
  endtask

  function automatic logic [7:0] rand_pos();
    logic [7:0] p;
    if ($urandom_range(99) < 85) p = 8'($urandom_range(0, BufferChars - 1));
    else p = 8'($urandom_range(0, 255));
    return p;
  endfunction

  // Mostly digits and letters so that bumps walk through their ranges.
  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    case ($urandom_range(4))
      0: c = 8'($urandom_range(ZeroChar, NineChar));
      1: c = 8'($urandom_range(LowAChar, LowZChar));
      2: c = $urandom_range(1) ? NineChar : LowZChar - 8'd1;
      default: c = 8'($urandom);
    endcase
    return c;
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = '0;
      1: v = '1;
      2, 3: v = $urandom_range(0, 999);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] rand_count();
    logic [5:0] n;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) n = 6'($urandom_range(0, 12));
    else if (r < 95) n = 6'($urandom_range(13, 32));
    else n = 6'($urandom_range(33, 63));
    return n;
  endfunction

  initial begin
    int unsigned r;
    int unsigned len;
    logic [7:0] base;
    bit drained;
    drained = 0;
    sb = new;
    sb.reset_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Init sequence, then the first buffer byte.
    repeat (InitLen + 1) send_item(FUNC_TICK, 8'd0, 8'd0, 32'd0, 6'd0);
    // Fill the whole buffer with zeros; the digits past the end are dropped.
    send_item(FUNC_VALUE, 8'd0, 8'd0, 32'd0, 6'd40);
    send_item(FUNC_CHAR, 8'd0, 8'hFF, 32'd0, 6'd0);
    send_item(FUNC_CHAR, 8'd31, 8'h00, 32'd0, 6'd0);
    send_item(FUNC_CHAR, 8'd255, 8'h58, 32'd0, 6'd0);
    send_item(FUNC_BUMP, 8'd1, 8'd0, 32'd0, 6'd0);
    send_item(FUNC_BUMP, 8'd33, 8'd0, 32'd0, 6'd0);
    send_item(FUNC_CHAR, 8'd2, NineChar, 32'd0, 6'd0);
    send_item(FUNC_BUMP, 8'd2, 8'd0, 32'd0, 6'd0);
    send_item(FUNC_CHAR, 8'd3, LowZChar, 32'd0, 6'd0);
    send_item(FUNC_BUMP, 8'd3, 8'd0, 32'd0, 6'd0);
    send_item(FUNC_BUMP, 8'd0, 8'd0, 32'd0, 6'd0);
    send_item(FUNC_VALUE, 8'd4, 8'd0, 32'hFFFF_FFFF, 6'd10);
    send_item(FUNC_VALUE, 8'd26, 8'd0, 32'd12345678, 6'd8);
    send_item(FUNC_VALUE, 8'd14, 8'd0, 32'd123, 6'd2);
    send_item(FUNC_VALUE, 8'd20, 8'd0, 32'd7, 6'd0);
    send_item(FUNC_VALUE, 8'd21, 8'd0, 32'd0, 6'd0);
    send_item(FUNC_VALUE, 8'd200, 8'hFF, 32'hFFFF_FFFF, 6'd63);

    while (items_sent < 950) begin
      steady <= (items_sent >= 300 && items_sent < 480);
      if (!drained && items_sent >= 600) begin
        // Hold off the sender until every pending tick has produced its byte.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.tx_bytes_due.size() != 0) @(posedge clk_i);
        drained = 1;
      end
      r = $urandom_range(99);
      if (r < 40) begin
        send_item(FUNC_TICK, rand_pos(), rand_char(), rand_value(), rand_count());
      end else if (r < 50) begin
        // A short string sent as consecutive char writes.
        len = $urandom_range(3, 8);
        base = 8'($urandom_range(0, BufferChars - 1));
        for (int j = 0; j < len; j++) begin
          send_item(FUNC_CHAR, base + 8'(j), rand_char(), rand_value(), rand_count());
        end
      end else if (r < 65) begin
        send_item(FUNC_CHAR, rand_pos(), rand_char(), rand_value(), rand_count());
      end else if (r < 80) begin
        send_item(FUNC_BUMP, rand_pos(), rand_char(), rand_value(), rand_count());
      end else begin
        send_item(FUNC_VALUE, rand_pos(), rand_char(), rand_value(), rand_count());
      end
    end
    in_valid_i <= 1'b0;
    steady <= 1'b0;

    while (sb.tx_bytes_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
